### src/hhc_pkg.sv
// ----------------------------------------------------------------------------
// Heavy-hitter classifier package
// Field widths, configuration register indexes, outcome codes and the default
// values of the block parameters and registers.
// ----------------------------------------------------------------------------
package hhc_pkg;

   localparam int HASH_W     = 32;
   localparam int LEN_W      = 16;
   localparam int TIME_W     = 48;
   localparam int CTR_W      = 32;
   localparam int FLOW_W     = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int HHC_NUM_ARRAYS  = 4;
   localparam int HHC_ARRAY_DEPTH = 1024;
   localparam int HHC_INDEX_BITS  = 10;
   localparam int HHC_TABLE_SLOTS = 1024;
   localparam int HHC_SLOT_WAYS   = 4;
   localparam int HHC_FLOW_LIMIT  = 2048;

   localparam logic [CSR_IDX_W-1:0] CSR_ADMIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_INT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVICT_INT = 2'd2;

   localparam logic [CSR_DATA_W-1:0] ADMIT_RST     = 32'd128000;
   localparam logic [CSR_DATA_W-1:0] RESET_INT_RST = 32'd40000;
   localparam logic [CSR_DATA_W-1:0] EVICT_INT_RST = 32'd1000000;

   typedef enum logic [1:0] {
      OUT_HIT     = 2'd0,
      OUT_ADMIT   = 2'd1,
      OUT_REFUSED = 2'd2,
      OUT_BELOW   = 2'd3
   } outcome_type;

endpackage

### src/hhc_req_if.sv
// ----------------------------------------------------------------------------
// Heavy-hitter classifier request channel
// Valid/ready channel carrying one packet descriptor per transfer.
// ----------------------------------------------------------------------------
interface hhc_req_if import hhc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] flow_hash;
   logic [LEN_W-1:0]  pkt_len;
   logic [TIME_W-1:0] now_time;

   modport source (output valid, output flow_hash, output pkt_len, output now_time,
                   input ready);
   modport sink   (input valid, input flow_hash, input pkt_len, input now_time,
                   output ready);
endinterface

### src/hhc_rsp_if.sv
// ----------------------------------------------------------------------------
// Heavy-hitter classifier response channel
// Valid/ready channel carrying one classification per transfer.
// ----------------------------------------------------------------------------
interface hhc_rsp_if import hhc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              heavy;
   outcome_type       outcome;
   logic [FLOW_W-1:0] active_flows;

   modport source (output valid, output heavy, output outcome, output active_flows,
                   input ready);
   modport sink   (input valid, input heavy, input outcome, input active_flows,
                   output ready);
endinterface

### src/heavy_hitter_classifier.sv
// A request is taken only in the idle state. The flow-table row and one counter
// per array are then read, evaluated and written back, and the response is
// registered, before the next request is taken; the write-back waits while an
// earlier response has not been taken. When TABLE_SLOTS is not a power of two,
// the slot comes from a reciprocal slot reduction. Reset is synchronous; afterwards
// a clearing pass zeroes the flow table, during which no request is taken.
// ----------------------------------------------------------------------------
// Heavy-hitter classifier
// Multistage counter filter with conservative update in front of a set-
// associative table of flows that have already been found heavy.
// ----------------------------------------------------------------------------
module heavy_hitter_classifier import hhc_pkg::*; #(
   parameter int NUM_ARRAYS  = HHC_NUM_ARRAYS,
   parameter int ARRAY_DEPTH = HHC_ARRAY_DEPTH,
   parameter int INDEX_BITS  = HHC_INDEX_BITS,
   parameter int TABLE_SLOTS = HHC_TABLE_SLOTS,
   parameter int SLOT_WAYS   = HHC_SLOT_WAYS,
   parameter int FLOW_LIMIT  = HHC_FLOW_LIMIT
) (
   input  logic                  clock,
   input  logic                  reset,
   hhc_req_if.sink               req_ch,
   hhc_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W     = $clog2(ARRAY_DEPTH);
   localparam int SLOT_W    = $clog2(TABLE_SLOTS);
   localparam int WIX_W     = (SLOT_WAYS > 1) ? $clog2(SLOT_WAYS) : 1;
   localparam int WCNT_W    = $clog2(SLOT_WAYS + 1);
   localparam int WAY_W     = 1 + HASH_W + TIME_W;
   localparam int RED_W     = ((INDEX_BITS > PTR_W) ? INDEX_BITS : PTR_W) + 1;
   localparam bit SLOT_POW2 = ((1 << SLOT_W) == TABLE_SLOTS);
   localparam int PROD_W    = 2 * HASH_W + 1;
   localparam int SHIFT_W   = HASH_W + SLOT_W;
   localparam logic [HASH_W:0] RECIP = (HASH_W+1)'(
      ((65'd1 << SHIFT_W) + 65'(TABLE_SLOTS) - 65'd1) / 65'(TABLE_SLOTS));

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_MOD  = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_DEC  = 3'd4;

   function automatic logic [PTR_W-1:0] reduce_idx(input logic [INDEX_BITS-1:0] v);
      logic [RED_W-1:0] t;
      t = RED_W'(v);
      for (int k = 0; k < 4; k++) begin
         if (t >= RED_W'(ARRAY_DEPTH)) t = t - RED_W'(ARRAY_DEPTH);
      end
      return t[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] pos_of(input logic [HASH_W-1:0] h, input int a);
      logic [HASH_W-1:0]     chunk;
      logic [INDEX_BITS-1:0] xs;
      logic [INDEX_BITS-1:0] sel;
      chunk = h;
      xs    = '0;
      sel   = '0;
      for (int k = 0; k < NUM_ARRAYS - 1; k++) begin
         if (k == a) sel = chunk[INDEX_BITS-1:0];
         xs    = xs ^ chunk[INDEX_BITS-1:0];
         chunk = chunk >> INDEX_BITS;
      end
      if (a == NUM_ARRAYS - 1) sel = xs ^ chunk[INDEX_BITS-1:0];
      return reduce_idx(sel);
   endfunction

   function automatic logic [4:0] grp_of(input logic [PTR_W-1:0] p);
      logic [31:0] w;
      w = 32'(p) >> 5;
      return w[4:0];
   endfunction

   // Control and configuration registers
   logic [2:0]            state_ff, state_in;
   logic [SLOT_W-1:0]     clr_ptr_ff, clr_ptr_in;
   logic                  step_ff, step_in;
   logic [CTR_W-1:0]      admit_ff, admit_in;
   logic [CTR_W-1:0]      rint_ff, rint_in;
   logic [CTR_W-1:0]      evict_ff, evict_in;
   logic [NUM_ARRAYS-1:0][31:0] grp_valid_ff, grp_valid_in;
   logic [TIME_W-1:0]     last_reset_ff, last_reset_in;
   logic [FLOW_W-1:0]     flow_count_ff, flow_count_in;
   logic [31:0]           refused_ff, refused_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [HASH_W-1:0]     quot_ff, quot_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [PTR_W-1:0]      pos_ff [NUM_ARRAYS];
   logic [PTR_W-1:0]      pos_in [NUM_ARRAYS];
   logic [SLOT_WAYS-1:0]  exp_ff, exp_in;
   logic [SLOT_WAYS-1:0]  match_ff, match_in;
   logic [SLOT_WAYS-1:0]  vp_ff, vp_in;
   logic [CTR_W-1:0]      eff_ff [NUM_ARRAYS];
   logic [CTR_W-1:0]      eff_in [NUM_ARRAYS];
   logic [CTR_W-1:0]      sum_ff [NUM_ARRAYS];
   logic [CTR_W-1:0]      sum_in [NUM_ARRAYS];
   logic                  rsp_heavy_ff, rsp_heavy_in;
   outcome_type           rsp_outcome_ff, rsp_outcome_in;
   logic [FLOW_W-1:0]     rsp_active_ff, rsp_active_in;

   // Memory ports
   logic [SLOT_WAYS-1:0][WAY_W-1:0] tbl_mem [TABLE_SLOTS];
   logic [SLOT_WAYS-1:0][WAY_W-1:0] tbl_rd_ff;
   logic [SLOT_WAYS-1:0][WAY_W-1:0] tbl_wdata;
   logic                  tbl_re, tbl_we;
   logic [SLOT_W-1:0]     tbl_raddr, tbl_waddr;
   logic                  ctr_re, ctr_we;
   logic [PTR_W-1:0]      ctr_raddr [NUM_ARRAYS];
   logic [CTR_W-1:0]      ctr_wdata [NUM_ARRAYS];
   logic [CTR_W-1:0]      ctr_rd_ff [NUM_ARRAYS];

   // Decision logic
   logic [PROD_W-1:0]     quot_prod;
   logic [HASH_W-1:0]     rem_full;
   logic [SLOT_W-1:0]     slot_rem;
   logic [SLOT_WAYS-1:0]  keep, new_exp, vp_hi;
   logic                  stop, hit, reuse_found, admit;
   logic [WIX_W-1:0]      hit_way, reuse_idx;
   logic [WCNT_W-1:0]     drops, wp;
   logic [SLOT_WAYS-1:0][WAY_W-1:0] new_row, fin_row;
   logic [FLOW_W-1:0]     fc_dec, fc_fin;
   logic [CTR_W-1:0]      minv;
   logic                  dec_heavy, dec_refused;
   outcome_type           dec_outcome;
   logic                  do_dec;
   logic [TIME_W:0]       stamp_sum;
   logic [CTR_W:0]        raw_sum;

   assign quot_prod = PROD_W'(hash_ff) * PROD_W'(RECIP);
   assign rem_full  = hash_ff - quot_ff * HASH_W'(TABLE_SLOTS);
   assign slot_rem  = rem_full[SLOT_W-1:0];
   assign do_dec    = (state_ff == S_DEC) && (!rsp_valid_ff || rsp_ch.ready);
   assign vp_hi     = vp_ff >> 1;

   // Flow table memory, one slot per row
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      if (tbl_re) tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   // One counter bank per array
   for (genvar g = 0; g < NUM_ARRAYS; g++) begin : g_bank
      logic [CTR_W-1:0] bank_mem [ARRAY_DEPTH];
      always_ff @(posedge clock) begin
         if (ctr_we) bank_mem[pos_ff[g]] <= ctr_wdata[g];
         if (ctr_re) ctr_rd_ff[g] <= bank_mem[ctr_raddr[g]];
      end
   end

   // Way scan, compaction and admission decision
   always_comb begin
      stop        = 1'b0;
      hit         = 1'b0;
      hit_way     = '0;
      drops       = '0;
      keep        = '0;
      new_row     = '0;
      new_exp     = '0;
      wp          = '0;
      reuse_found = 1'b0;
      reuse_idx   = '0;
      for (int i = 0; i < SLOT_WAYS; i++) begin
         if (vp_ff[i]) begin
            if (stop) begin
               keep[i] = 1'b1;
            end else if (exp_ff[i]) begin
               // The last valid way of a slot is kept even when it has expired.
               if (!vp_hi[i]) begin
                  keep[i] = 1'b1;
                  stop    = 1'b1;
               end else begin
                  drops = drops + 1'b1;
               end
            end else if (match_ff[i]) begin
               keep[i] = 1'b1;
               stop    = 1'b1;
               hit     = 1'b1;
               hit_way = WIX_W'(i);
            end else begin
               keep[i] = 1'b1;
            end
         end
      end
      for (int i = 0; i < SLOT_WAYS; i++) begin
         if (keep[i]) begin
            new_row[wp[WIX_W-1:0]] = {1'b1, tbl_rd_ff[i][HASH_W+TIME_W-1:TIME_W],
               (hit && hit_way == WIX_W'(i)) ? now_ff : tbl_rd_ff[i][TIME_W-1:0]};
            new_exp[wp[WIX_W-1:0]] = exp_ff[i];
            wp = wp + 1'b1;
         end
      end
      for (int i = 0; i < SLOT_WAYS; i++) begin
         if (!reuse_found && new_exp[i]) begin
            reuse_found = 1'b1;
            reuse_idx   = WIX_W'(i);
         end
      end
      fc_dec = (flow_count_ff > FLOW_W'(drops)) ? flow_count_ff - FLOW_W'(drops) : '0;
      minv = sum_ff[0];
      for (int a = 1; a < NUM_ARRAYS; a++) begin
         if (sum_ff[a] < minv) minv = sum_ff[a];
      end
      admit       = minv > admit_ff;
      fin_row     = new_row;
      fc_fin      = fc_dec;
      dec_heavy   = 1'b0;
      dec_refused = 1'b0;
      dec_outcome = OUT_BELOW;
      if (hit) begin
         dec_heavy   = 1'b1;
         dec_outcome = OUT_HIT;
      end else if (admit) begin
         if (reuse_found) begin
            fin_row[reuse_idx] = {1'b1, hash_ff, now_ff};
            dec_heavy   = 1'b1;
            dec_outcome = OUT_ADMIT;
         end else if (fc_dec < FLOW_W'(FLOW_LIMIT) && wp < WCNT_W'(SLOT_WAYS)) begin
            fin_row[wp[WIX_W-1:0]] = {1'b1, hash_ff, now_ff};
            fc_fin      = fc_dec + 1'b1;
            dec_heavy   = 1'b1;
            dec_outcome = OUT_ADMIT;
         end else begin
            dec_refused = 1'b1;
            dec_outcome = OUT_REFUSED;
         end
      end
      for (int a = 0; a < NUM_ARRAYS; a++) begin
         ctr_wdata[a] = (!admit && eff_ff[a] < minv) ? minv : eff_ff[a];
      end
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      clr_ptr_in     = clr_ptr_ff;
      step_in        = step_ff;
      admit_in       = admit_ff;
      rint_in        = rint_ff;
      evict_in       = evict_ff;
      grp_valid_in   = grp_valid_ff;
      last_reset_in  = last_reset_ff;
      flow_count_in  = flow_count_ff;
      refused_in     = refused_ff;
      rsp_valid_in   = rsp_valid_ff;
      quot_in        = quot_ff;
      hash_in        = hash_ff;
      len_in         = len_ff;
      now_in         = now_ff;
      slot_in        = slot_ff;
      exp_in         = exp_ff;
      match_in       = match_ff;
      vp_in          = vp_ff;
      rsp_heavy_in   = rsp_heavy_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_active_in  = rsp_active_ff;
      tbl_re         = 1'b0;
      tbl_we         = 1'b0;
      tbl_raddr      = req_ch.flow_hash[SLOT_W-1:0];
      tbl_waddr      = slot_ff;
      tbl_wdata      = fin_row;
      ctr_re         = 1'b0;
      ctr_we         = 1'b0;
      stamp_sum      = '0;
      raw_sum        = '0;
      for (int a = 0; a < NUM_ARRAYS; a++) begin
         pos_in[a]    = pos_ff[a];
         eff_in[a]    = eff_ff[a];
         sum_in[a]    = sum_ff[a];
         ctr_raddr[a] = (state_ff == S_IDLE) ? pos_of(req_ch.flow_hash, a) : pos_ff[a];
      end

      if (csr_we) begin
         case (csr_index)
            CSR_ADMIT:     admit_in = csr_wdata;
            CSR_RESET_INT: rint_in  = csr_wdata;
            CSR_EVICT_INT: evict_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLR: begin
            tbl_we     = 1'b1;
            tbl_waddr  = clr_ptr_ff;
            tbl_wdata  = '0;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == SLOT_W'(TABLE_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               hash_in = req_ch.flow_hash;
               len_in  = req_ch.pkt_len;
               now_in  = req_ch.now_time;
               for (int a = 0; a < NUM_ARRAYS; a++) pos_in[a] = ctr_raddr[a];
               if ((TIME_W+1)'(last_reset_ff) + (TIME_W+1)'(rint_ff) <
                   (TIME_W+1)'(req_ch.now_time)) begin
                  grp_valid_in  = '0;
                  last_reset_in = req_ch.now_time;
               end
               if (SLOT_POW2) begin
                  tbl_re   = 1'b1;
                  ctr_re   = 1'b1;
                  slot_in  = req_ch.flow_hash[SLOT_W-1:0];
                  state_in = S_EVAL;
               end else begin
                  step_in  = 1'b0;
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            // The quotient by TABLE_SLOTS comes from a reciprocal multiplication;
            // the remainder is then formed from the registered quotient.
            if (!step_ff) begin
               quot_in = HASH_W'(quot_prod >> SHIFT_W);
               step_in = 1'b1;
            end else begin
               tbl_re    = 1'b1;
               tbl_raddr = slot_rem;
               ctr_re    = 1'b1;
               slot_in   = slot_rem;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            for (int i = 0; i < SLOT_WAYS; i++) begin
               stamp_sum   = (TIME_W+1)'(tbl_rd_ff[i][TIME_W-1:0]) + (TIME_W+1)'(evict_ff);
               exp_in[i]   = stamp_sum < (TIME_W+1)'(now_ff);
               match_in[i] = tbl_rd_ff[i][HASH_W+TIME_W-1:TIME_W] == hash_ff;
               vp_in[i]    = tbl_rd_ff[i][WAY_W-1] && ((i == 0) ? 1'b1 : vp_in[(i + SLOT_WAYS - 1) % SLOT_WAYS]);
            end
            for (int a = 0; a < NUM_ARRAYS; a++) begin
               // A counter whose group has not been touched since the last clear reads as zero.
               eff_in[a] = grp_valid_ff[a][grp_of(pos_ff[a])] ? ctr_rd_ff[a] : '0;
               raw_sum   = (CTR_W+1)'(eff_in[a]) + (CTR_W+1)'(len_ff);
               sum_in[a] = raw_sum[CTR_W] ? '1 : raw_sum[CTR_W-1:0];
            end
            state_in = S_DEC;
         end
         S_DEC: begin
            if (do_dec) begin
               tbl_we         = 1'b1;
               flow_count_in  = fc_fin;
               rsp_valid_in   = 1'b1;
               rsp_heavy_in   = dec_heavy;
               rsp_outcome_in = dec_outcome;
               rsp_active_in  = fc_fin;
               if (dec_refused) refused_in = refused_ff + 1'b1;
               if (!hit) begin
                  ctr_we = 1'b1;
                  for (int a = 0; a < NUM_ARRAYS; a++) begin
                     grp_valid_in[a][grp_of(pos_ff[a])] = 1'b1;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_ptr_ff    <= '0;
         step_ff       <= 1'b0;
         admit_ff      <= ADMIT_RST;
         rint_ff       <= RESET_INT_RST;
         evict_ff      <= EVICT_INT_RST;
         grp_valid_ff  <= '0;
         last_reset_ff <= '0;
         flow_count_ff <= '0;
         refused_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         step_ff       <= step_in;
         admit_ff      <= admit_in;
         rint_ff       <= rint_in;
         evict_ff      <= evict_in;
         grp_valid_ff  <= grp_valid_in;
         last_reset_ff <= last_reset_in;
         flow_count_ff <= flow_count_in;
         refused_ff    <= refused_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff        <= quot_in;
      hash_ff        <= hash_in;
      len_ff         <= len_in;
      now_ff         <= now_in;
      slot_ff        <= slot_in;
      exp_ff         <= exp_in;
      match_ff       <= match_in;
      vp_ff          <= vp_in;
      rsp_heavy_ff   <= rsp_heavy_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_active_ff  <= rsp_active_in;
      for (int a = 0; a < NUM_ARRAYS; a++) begin
         pos_ff[a] <= pos_in[a];
         eff_ff[a] <= eff_in[a];
         sum_ff[a] <= sum_in[a];
      end
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.heavy        = rsp_heavy_ff;
   assign rsp_ch.outcome      = rsp_outcome_ff;
   assign rsp_ch.active_flows = rsp_active_ff;

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !req_ch.ready)
      else $error("request taken during the table clearing pass");

   a_flow_limit: assert property (@(posedge clock) disable iff (reset)
      flow_count_ff <= FLOW_W'(FLOW_LIMIT))
      else $error("flow count above the flow limit");

   a_heavy_matches_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_heavy_ff == (rsp_outcome_ff == OUT_HIT ||
                                         rsp_outcome_ff == OUT_ADMIT)))
      else $error("heavy flag disagrees with outcome");

   a_count_only_on_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DEC) |=> (flow_count_ff == $past(flow_count_ff)))
      else $error("flow count changed outside the decision cycle");

endmodule
